// ----- hdl/dtpw_pkg.sv -----
// Shared types and constants of the depth-tested pixel writer.
// Holds the input and result words, operation and state codes, and register indexes.
// Depends on nothing; every other file imports it.
`default_nettype none

package dtpw_pkg;

  localparam int DIM_W    = 9;
  localparam int COORD_W  = 16;
  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int DEPTH_W  = 24;
  localparam int LOC_W    = 2 * DIM_W;

  localparam logic [DEPTH_W-1:0] FAR_DEPTH = {DEPTH_W{1'b1}};
  localparam logic [DIM_W-1:0]   RESET_DIM = 9'd256;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR      = 2'd0,
    OP_DRAW       = 2'd1,
    OP_DEPTH_DRAW = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [DEPTH_W-1:0]        new_depth;
    logic [CHAN_W-1:0]         colour_red;
    logic [CHAN_W-1:0]         colour_green;
    logic [CHAN_W-1:0]         colour_blue;
  } in_word_t;

  typedef struct packed {
    logic              was_written;
    logic              outside_frame;
    logic              depth_rejected;
    logic [CHAN_W-1:0] read_red;
    logic [CHAN_W-1:0] read_green;
    logic [CHAN_W-1:0] read_blue;
  } out_word_t;

  typedef struct packed {
    logic             in_area;
    logic [LOC_W-1:0] index;
    logic [LOC_W-1:0] area;
  } loc_t;

endpackage

`default_nettype wire

// ----- hdl/dtpw_locate.sv -----
// Coordinate check and store index for the depth-tested pixel writer.
// Saturates the frame size, tests a position and forms y * width + x and the clear area.
// Depends on dtpw_pkg.
`default_nettype none

module dtpw_locate #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic [dtpw_pkg::DIM_W-1:0]          frame_width,
  input  wire logic [dtpw_pkg::DIM_W-1:0]          frame_height,
  input  wire logic signed [dtpw_pkg::COORD_W-1:0] pos_x,
  input  wire logic signed [dtpw_pkg::COORD_W-1:0] pos_y,
  output dtpw_pkg::loc_t                           loc
);
  import dtpw_pkg::*;

  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

  logic [DIM_W-1:0] act_w;
  logic [DIM_W-1:0] act_h;
  logic             x_in;
  logic             y_in;

  always_comb begin
    act_w = ({4'd0, frame_width} > MAXW) ? MAXW[DIM_W-1:0] : frame_width;
    act_h = ({4'd0, frame_height} > MAXH) ? MAXH[DIM_W-1:0] : frame_height;
    x_in  = !pos_x[COORD_W-1] && ($unsigned(pos_x) < {7'd0, act_w});
    y_in  = !pos_y[COORD_W-1] && ($unsigned(pos_y) < {7'd0, act_h});
    loc.in_area = x_in && y_in;
    loc.index  = ({9'd0, pos_y[DIM_W-1:0]} * {9'd0, act_w}) + {9'd0, pos_x[DIM_W-1:0]};
    loc.area   = {9'd0, act_w} * {9'd0, act_h};
  end

endmodule

`default_nettype wire

// ----- hdl/depth_tested_pixel_writer.sv -----
// Depth-tested pixel writer: colour and depth frame store with a read-modify-write sequencer.
// Holds both store memories, the control sequence, configuration and the result register.
// Depends on dtpw_pkg and dtpw_locate.
//
// Use: words enter on in_valid/in_word and leave on out_valid/out_word; a word moves at
// an edge where valid is high and stall is low. Every input word gives one result word.
// Draw, depth draw and read go through accept, memory read, then depth test and
// write-back into the result register. The next word is taken in the cycle after that,
// so a word is taken only once the last one has made its single read-modify-write pass
// through the stores.
// A clear writes active width times active height pixels (one pixel a cycle through the
// write port), then gives its result word. After reset the block sweeps the whole store,
// writing black and the far depth to all MAX_WIDTH * MAX_HEIGHT pixels; in_stall stays
// high during the sweep. Frame size resets to 256 by 256; the user sets it through
// cfg_wr_en/cfg_index/cfg_data only while the block is idle, which the block itself does
// not enforce. A held result register lets work finish while out_stall is high; the
// sequencer waits only when it must load a new result and the register is still occupied.
`default_nettype none

module depth_tested_pixel_writer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [dtpw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dtpw_pkg::DIM_W-1:0]         cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire dtpw_pkg::in_word_t                 in_word,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output dtpw_pkg::out_word_t                     out_word
);
  import dtpw_pkg::*;

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int CW         = AW + 1;

  logic [COLOUR_W-1:0] colour_mem [STORE_SIZE];
  logic [DEPTH_W-1:0]  depth_mem  [STORE_SIZE];

  logic [DIM_W-1:0]    frame_width_r, frame_width_nxt;
  logic [DIM_W-1:0]    frame_height_r, frame_height_nxt;
  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic                inside_r, inside_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [COLOUR_W-1:0] colour_r, colour_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       area_r, area_nxt;
  logic                report_r, report_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;
  logic [COLOUR_W-1:0] rd_colour_r;
  logic [DEPTH_W-1:0]  rd_depth_r;

  loc_t                loc;
  logic                accept;
  logic                out_free;
  logic                sweep_busy;
  logic                nearer;
  logic                mem_re;
  logic                colour_we;
  logic                depth_we;
  logic [AW-1:0]       mem_waddr;
  logic [DEPTH_W-1:0]  mem_wdepth;
  logic                load_out;
  out_word_t           result;

  dtpw_locate #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_locate (
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .pos_x        (in_word.pos_x),
    .pos_y        (in_word.pos_y),
    .loc          (loc)
  );

  assign accept     = in_valid && (state_r == ST_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign sweep_busy = (cnt_r < area_r);
  assign nearer     = (depth_r < rd_depth_r);
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;

  // configuration registers
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_data;
        CFG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_word.operation == OP_CLEAR) ? ST_SWEEP : ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (!sweep_busy && (!report_r || out_free)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_re     = 1'b0;
    colour_we  = 1'b0;
    depth_we   = 1'b0;
    load_out   = 1'b0;
    mem_waddr  = addr_r;
    mem_wdepth = depth_r;
    result     = '0;
    unique case (state_r)
      ST_IDLE: ;
      ST_READ: mem_re = 1'b1;
      ST_EXEC: begin
        load_out = out_free;
        if (!inside_r) begin
          result.outside_frame = 1'b1;
        end else begin
          case (op_r)
            OP_DRAW: begin
              colour_we          = out_free;
              result.was_written = 1'b1;
            end
            OP_DEPTH_DRAW: begin
              if (nearer) begin
                colour_we          = out_free;
                depth_we           = out_free;
                result.was_written = 1'b1;
              end else begin
                result.depth_rejected = 1'b1;
              end
            end
            OP_READ: begin
              result.read_red   = rd_colour_r[COLOUR_W-1 -: CHAN_W];
              result.read_green = rd_colour_r[CHAN_W +: CHAN_W];
              result.read_blue  = rd_colour_r[CHAN_W-1:0];
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        mem_waddr  = cnt_r[AW-1:0];
        mem_wdepth = FAR_DEPTH;
        if (sweep_busy) begin
          colour_we = 1'b1;
          depth_we  = 1'b1;
        end else begin
          load_out           = report_r && out_free;
          result.was_written = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // item registers and result register
  always_comb begin
    op_nxt        = op_r;
    inside_nxt    = inside_r;
    addr_nxt      = addr_r;
    depth_nxt     = depth_r;
    colour_nxt    = colour_r;
    cnt_nxt       = cnt_r;
    area_nxt      = area_r;
    report_nxt    = report_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      op_nxt     = in_word.operation;
      inside_nxt = loc.in_area;
      addr_nxt   = AW'(loc.index);
      depth_nxt  = in_word.new_depth;
      colour_nxt = {in_word.colour_red, in_word.colour_green, in_word.colour_blue};
      cnt_nxt    = '0;
      area_nxt   = CW'(loc.area);
      report_nxt = 1'b1;
    end
    if ((state_r == ST_SWEEP) && sweep_busy) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (load_out) begin
      out_word_nxt  = result;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RESET_DIM;
      frame_height_r <= RESET_DIM;
      state_r        <= ST_SWEEP;
      cnt_r          <= '0;
      area_r         <= CW'(STORE_SIZE);
      report_r       <= 1'b0;
      colour_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      area_r         <= area_nxt;
      report_r       <= report_nxt;
      colour_r       <= colour_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    inside_r   <= inside_nxt;
    addr_r     <= addr_nxt;
    depth_r    <= depth_nxt;
    out_word_r <= out_word_nxt;
  end

  // frame store
  always_ff @(posedge clk) begin
    if (colour_we) begin
      colour_mem[mem_waddr] <= colour_r;
    end
    if (depth_we) begin
      depth_mem[mem_waddr] <= mem_wdepth;
    end
    if (mem_re) begin
      rd_colour_r <= colour_mem[addr_r];
      rd_depth_r  <= depth_mem[addr_r];
    end
  end

  a_depth_only_nearer: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_we && (state_r == ST_EXEC)) |-> (inside_r && nearer && (op_r == OP_DEPTH_DRAW)))
    else $error("depth written without passing the depth test");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_word_r.was_written, out_word_r.outside_frame,
                              out_word_r.depth_rejected}))
    else $error("result word carries more than one status flag");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while one is in progress");

  a_exec_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EXEC) && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished word not loaded into the result register");

  a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (colour_we || depth_we) |-> !mem_re)
    else $error("store read and write issued together");

endmodule

`default_nettype wire
